// File: src/cfd_pkg.sv
package cfd_pkg;

  localparam int DATA_W      = 32;
  localparam int POS_OUT_W   = 4;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_PAD_W   = OUT_TDATA_W - 3 * DATA_W - POS_OUT_W;

  // register stages inside one delta unit
  localparam int DIV_LAT = 4;

  typedef logic signed [DATA_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = 32'sh7fff_ffff;
  localparam sample_t SAMPLE_MIN = 32'sh8000_0000;

endpackage

// File: src/cfd_delta.sv
module cfd_delta #(
  parameter int DELTA_TAPS = 4
) (
  input  logic             clk,
  input  logic             en,
  input  cfd_pkg::sample_t cur,
  input  cfd_pkg::sample_t taps [DELTA_TAPS],
  output cfd_pkg::sample_t delta
);
  import cfd_pkg::*;

  localparam int TAP_SUM = DELTA_TAPS * (DELTA_TAPS + 1) / 2;
  localparam int DEN     = DELTA_TAPS * (DELTA_TAPS + 1) * (2 * DELTA_TAPS + 1) / 6;
  localparam int DIV_M   = 2 * DEN;
  localparam int SUM_W   = DATA_W + 2 + $clog2(TAP_SUM + 1);
  localparam int N_W     = SUM_W + 1;
  localparam int N_LO    = N_W / 2;
  localparam int N_HI    = N_W - N_LO;
  localparam int K_SH    = N_W + $clog2(DIV_M);
  localparam int R_W     = N_W + 2;
  localparam int R_LO    = R_W / 2;
  localparam int R_HI    = R_W - R_LO;
  localparam int P_W     = N_W + R_W;
  localparam int Q_W     = P_W - K_SH;

  localparam logic [63:0] RECIP = ((64'd1 << K_SH) + 64'(DIV_M) - 64'd1) / 64'(DIV_M);
  localparam logic [R_LO-1:0] RECIP_LO = RECIP[R_LO-1:0];
  localparam logic [R_HI-1:0] RECIP_HI = RECIP[R_W-1:R_LO];

  logic signed [SUM_W-1:0] sum_c;
  logic signed [SUM_W-1:0] sum_r;
  logic        [SUM_W-1:0] mag_c;
  logic        [N_W-1:0]   num_r;
  logic                    neg2_r;
  logic                    neg3_r;
  logic [N_LO+R_LO-1:0]    pp_ll_r;
  logic [N_LO+R_HI-1:0]    pp_lh_r;
  logic [N_HI+R_LO-1:0]    pp_hl_r;
  logic [N_HI+R_HI-1:0]    pp_hh_r;
  logic [P_W-1:0]          full_c;
  logic [Q_W-1:0]          quo_c;
  sample_t                 delta_nxt;
  sample_t                 delta_r;

  // weighted difference sum over the taps
  always_comb begin
    logic signed [DATA_W:0]  diff;
    logic signed [SUM_W-1:0] wgt;
    sum_c = '0;
    for (int n = 1; n <= DELTA_TAPS; n++) begin
      diff  = (DATA_W+1)'(cur) - (DATA_W+1)'(taps[n-1]);
      wgt   = SUM_W'(n);
      sum_c = sum_c + SUM_W'(diff) * wgt;
    end
  end

  assign mag_c = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  assign full_c = P_W'(pp_ll_r)
                + (P_W'(pp_lh_r) << R_LO)
                + (P_W'(pp_hl_r) << N_LO)
                + (P_W'(pp_hh_r) << (N_LO + R_LO));
  assign quo_c  = full_c[P_W-1:K_SH];

  // round-half-away quotient, saturated to the sample range
  always_comb begin
    if (neg3_r) begin
      if (quo_c > Q_W'(64'h8000_0000)) begin
        delta_nxt = SAMPLE_MIN;
      end else begin
        delta_nxt = -sample_t'(quo_c[DATA_W-1:0]);
      end
    end else begin
      if (quo_c > Q_W'(64'h7fff_ffff)) begin
        delta_nxt = SAMPLE_MAX;
      end else begin
        delta_nxt = sample_t'(quo_c[DATA_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= sum_c;
      neg2_r  <= sum_r[SUM_W-1];
      num_r   <= {mag_c, 1'b0} + N_W'(DEN);
      neg3_r  <= neg2_r;
      pp_ll_r <= (N_LO+R_LO)'(num_r[N_LO-1:0]) * (N_LO+R_LO)'(RECIP_LO);
      pp_lh_r <= (N_LO+R_HI)'(num_r[N_LO-1:0]) * (N_LO+R_HI)'(RECIP_HI);
      pp_hl_r <= (N_HI+R_LO)'(num_r[N_W-1:N_LO]) * (N_HI+R_LO)'(RECIP_LO);
      pp_hh_r <= (N_HI+R_HI)'(num_r[N_W-1:N_LO]) * (N_HI+R_HI)'(RECIP_HI);
      delta_r <= delta_nxt;
    end
  end

  assign delta = delta_r;

endmodule

// File: src/causal_delta_feature_stage_core.sv
// channel  direction  ports                          payload
// in       slave      in_tvalid in_tready in_tdata   coef_value
// out      master     out_tvalid out_tready          static, delta, delta2, position
//                     out_tdata out_tlast            frame end on tlast
//
// one transaction per cycle in and out unless the output stalls; the output is registered
// two delta units of four register stages each, with a history line between them
// reset clears the history lines, the position counter and all valid flags at once
// the whole pipeline holds while out_tvalid is high and out_tready low; in_tready follows
module causal_delta_feature_stage_core #(
  parameter int NUM_COEF   = 13,
  parameter int DELTA_TAPS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [cfd_pkg::IN_TDATA_W-1:0]    in_tdata,   // [31:0] coef_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [cfd_pkg::OUT_TDATA_W-1:0]   out_tdata,  // static, delta, delta2, position, pad
  output logic                              out_tlast   // frame_end
);
  import cfd_pkg::*;

  localparam int CNT_W    = (NUM_COEF > 1) ? $clog2(NUM_COEF) : 1;
  localparam int LINE_LEN = DELTA_TAPS * NUM_COEF + 1;
  localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(NUM_COEF - 1);

  logic             en;
  logic             in_acc;
  logic [CNT_W-1:0] pos_cnt_r;

  sample_t          coef_line_r [LINE_LEN];
  sample_t          coef_taps   [DELTA_TAPS];
  logic             vld_c_r;
  logic [CNT_W-1:0] pos_c_r;

  sample_t          d1;
  sample_t          x1_r   [DIV_LAT];
  logic [CNT_W-1:0] pos1_r [DIV_LAT];
  logic             vld1_r [DIV_LAT];

  sample_t          delta_line_r [LINE_LEN];
  sample_t          delta_taps   [DELTA_TAPS];
  logic             vld_d_r;
  sample_t          x_d_r;
  logic [CNT_W-1:0] pos_d_r;

  sample_t          d2;
  sample_t          x2_r   [DIV_LAT];
  sample_t          d1_2_r [DIV_LAT];
  logic [CNT_W-1:0] pos2_r [DIV_LAT];
  logic             vld2_r [DIV_LAT];

  logic             out_valid_r;
  sample_t          out_x_r;
  sample_t          out_d1_r;
  sample_t          out_d2_r;
  logic [CNT_W-1:0] out_pos_r;
  logic [CNT_W+POS_OUT_W-1:0] pos_wide;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_cnt_r <= '0;
    end else if (in_acc) begin
      pos_cnt_r <= (pos_cnt_r == LAST_POS) ? '0 : pos_cnt_r + 1'b1;
    end
  end

  // coefficient history, one entry per transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_c_r <= 1'b0;
      for (int i = 0; i < LINE_LEN; i++) coef_line_r[i] <= '0;
    end else if (en) begin
      vld_c_r <= in_tvalid;
      if (in_tvalid) begin
        coef_line_r[0] <= sample_t'(in_tdata[DATA_W-1:0]);
        for (int i = 1; i < LINE_LEN; i++) coef_line_r[i] <= coef_line_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_c_r <= pos_cnt_r;
    end
  end

  always_comb begin
    for (int n = 1; n <= DELTA_TAPS; n++) begin
      coef_taps[n-1]  = coef_line_r[n*NUM_COEF];
      delta_taps[n-1] = delta_line_r[n*NUM_COEF];
    end
  end

  cfd_delta #(.DELTA_TAPS(DELTA_TAPS)) u_delta1 (
    .clk   (clk),
    .en    (en),
    .cur   (coef_line_r[0]),
    .taps  (coef_taps),
    .delta (d1)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) vld1_r[i] <= 1'b0;
    end else if (en) begin
      vld1_r[0] <= vld_c_r;
      for (int i = 1; i < DIV_LAT; i++) vld1_r[i] <= vld1_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r[0]   <= coef_line_r[0];
      pos1_r[0] <= pos_c_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        x1_r[i]   <= x1_r[i-1];
        pos1_r[i] <= pos1_r[i-1];
      end
    end
  end

  // delta history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
      for (int i = 0; i < LINE_LEN; i++) delta_line_r[i] <= '0;
    end else if (en) begin
      vld_d_r <= vld1_r[DIV_LAT-1];
      if (vld1_r[DIV_LAT-1]) begin
        delta_line_r[0] <= d1;
        for (int i = 1; i < LINE_LEN; i++) delta_line_r[i] <= delta_line_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld1_r[DIV_LAT-1]) begin
      x_d_r   <= x1_r[DIV_LAT-1];
      pos_d_r <= pos1_r[DIV_LAT-1];
    end
  end

  cfd_delta #(.DELTA_TAPS(DELTA_TAPS)) u_delta2 (
    .clk   (clk),
    .en    (en),
    .cur   (delta_line_r[0]),
    .taps  (delta_taps),
    .delta (d2)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DIV_LAT; i++) vld2_r[i] <= 1'b0;
    end else if (en) begin
      vld2_r[0] <= vld_d_r;
      for (int i = 1; i < DIV_LAT; i++) vld2_r[i] <= vld2_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r[0]   <= x_d_r;
      d1_2_r[0] <= delta_line_r[0];
      pos2_r[0] <= pos_d_r;
      for (int i = 1; i < DIV_LAT; i++) begin
        x2_r[i]   <= x2_r[i-1];
        d1_2_r[i] <= d1_2_r[i-1];
        pos2_r[i] <= pos2_r[i-1];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld2_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld2_r[DIV_LAT-1]) begin
      out_x_r   <= x2_r[DIV_LAT-1];
      out_d1_r  <= d1_2_r[DIV_LAT-1];
      out_d2_r  <= d2;
      out_pos_r <= pos2_r[DIV_LAT-1];
    end
  end

  assign pos_wide   = (CNT_W+POS_OUT_W)'(out_pos_r);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {OUT_PAD_W'(0), pos_wide[POS_OUT_W-1:0], out_d2_r, out_d1_r, out_x_r};
  assign out_tlast  = (out_pos_r == LAST_POS);

endmodule

// File: verif/tb_causal_delta_feature_stage_core.sv
`timescale 1ns / 1ps

module tb_causal_delta_feature_stage_core;
  import cfd_pkg::*;

  localparam int NCOEF = 13;
  localparam int TAPS  = 4;
  localparam int SLOTS = TAPS + 1;
  localparam int RANDOM_ITEMS = 1350;

  typedef sample_t hist_t [SLOTS][NCOEF];

  typedef struct {
    sample_t           stat_v;
    sample_t           delta_v;
    sample_t           delta2_v;
    logic [POS_OUT_W-1:0] pos;
    logic              last;
  } feature_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic out_tlast;

  sample_t  pending_coefs[$];
  feature_t expected_features[$];

  hist_t coef_hist;
  hist_t delta_hist;
  int    cur_slot;
  int    frames_begun;
  int    next_pos;

  int accepted_in;
  int errors;

  // no idling on either side while this is high
  wire steady = (accepted_in >= 400) && (accepted_in < 700);

  causal_delta_feature_stage_core #(
    .NUM_COEF  (NCOEF),
    .DELTA_TAPS(TAPS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic sample_t regress(input hist_t h, input int slot, input int pos);
    longint acc;
    longint mag;
    longint q;
    longint den;
    longint past;
    int     past_slot;
    int     n;
    acc = 0;
    den = 0;
    for (n = 1; n <= TAPS; n++) begin
      past_slot = (slot + SLOTS - n) % SLOTS;
      past = (frames_begun > n) ? longint'(h[past_slot][pos]) : 64'sd0;
      acc += longint'(n) * (longint'(h[slot][pos]) - past);
      den += n * n;
    end
    mag = (acc < 0) ? -acc : acc;
    q = (2 * mag + den) / (2 * den);
    if (acc < 0) begin
      if (q > 64'sd2147483648) return SAMPLE_MIN;
      return sample_t'(-q);
    end
    if (q > 64'sd2147483647) return SAMPLE_MAX;
    return sample_t'(q);
  endfunction

  task automatic track_feature(input sample_t x);
    int       pos;
    feature_t f;
    pos = (next_pos >= NCOEF) ? 0 : next_pos;
    if (pos == 0) begin
      cur_slot = (cur_slot + 1) % SLOTS;
      if (frames_begun < SLOTS) frames_begun++;
    end
    coef_hist[cur_slot][pos] = x;
    f.delta_v = regress(coef_hist, cur_slot, pos);
    delta_hist[cur_slot][pos] = f.delta_v;
    f.delta2_v = regress(delta_hist, cur_slot, pos);
    f.stat_v = x;
    f.pos = pos[POS_OUT_W-1:0];
    f.last = (pos == NCOEF - 1);
    expected_features.push_back(f);
    next_pos = (pos + 1 >= NCOEF) ? 0 : pos + 1;
  endtask

  function automatic sample_t pick_coef();
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 45) return sample_t'($urandom);
    if (mode < 65) return sample_t'(int'($urandom_range(0, 63)) - 32);
    if (mode < 80) begin
      case ($urandom_range(0, 4))
        0: return SAMPLE_MAX;
        1: return SAMPLE_MIN;
        2: return sample_t'(0);
        3: return sample_t'(-1);
        default: return sample_t'(1);
      endcase
    end
    return sample_t'(int'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_feature(sample_t'(in_tdata));
        accepted_in <= accepted_in + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_coefs.size() > 0 && (steady || $urandom_range(0, 99) >= 36)) begin
          in_tdata  <= pending_coefs.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    feature_t exp_f;
    feature_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.stat_v   = sample_t'(out_tdata[DATA_W-1:0]);
        got.delta_v  = sample_t'(out_tdata[2*DATA_W-1:DATA_W]);
        got.delta2_v = sample_t'(out_tdata[3*DATA_W-1:2*DATA_W]);
        got.pos      = out_tdata[3*DATA_W+POS_OUT_W-1:3*DATA_W];
        got.last     = out_tlast;
        if (expected_features.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transaction: static %h delta %h delta2 %h pos %0d last %b",
                     got.stat_v, got.delta_v, got.delta2_v, got.pos, got.last);
        end else begin
          exp_f = expected_features.pop_front();
          if (got.stat_v !== exp_f.stat_v || got.delta_v !== exp_f.delta_v ||
              got.delta2_v !== exp_f.delta2_v || got.pos !== exp_f.pos ||
              got.last !== exp_f.last) begin
            errors++;
            if (errors <= 10) begin
              $display("mismatch: exp static %h delta %h delta2 %h pos %0d last %b",
                       exp_f.stat_v, exp_f.delta_v, exp_f.delta2_v, exp_f.pos, exp_f.last);
              $display("          got static %h delta %h delta2 %h pos %0d last %b",
                       got.stat_v, got.delta_v, got.delta2_v, got.pos, got.last);
            end
          end
        end
      end
      out_tready <= steady || ($urandom_range(0, 99) >= 36);
    end
  end

  initial begin
    int i;
    sample_t directed[$];
    errors = 0;
    accepted_in = 0;
    cur_slot = 0;
    frames_begun = 0;
    next_pos = 0;
    for (i = 0; i < SLOTS * NCOEF; i++) begin
      coef_hist[i / NCOEF][i % NCOEF] = '0;
      delta_hist[i / NCOEF][i % NCOEF] = '0;
    end
    // extremes, rounding ties and sign flips across a frame boundary
    directed = '{SAMPLE_MAX, SAMPLE_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sh7fff_0000,
                 32'sh0001_0000, 32'sd15, -32'sd15, 32'sd45, -32'sd45, SAMPLE_MIN,
                 SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX, 32'sd0, 32'sd1, -32'sd1,
                 SAMPLE_MAX, SAMPLE_MIN, 32'sd3, -32'sd3, SAMPLE_MIN, SAMPLE_MAX, 32'sd0};
    foreach (directed[k]) pending_coefs.push_back(directed[k]);
    for (i = 0; i < RANDOM_ITEMS; i++) pending_coefs.push_back(pick_coef());

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_coefs.size() > 0 || in_tvalid || expected_features.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);

    if (errors == 0 && expected_features.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// File: filelist.f
src/cfd_pkg.sv
src/cfd_delta.sv
src/causal_delta_feature_stage_core.sv
verif/tb_causal_delta_feature_stage_core.sv
